FILE: src/fbu_pkg.sv
// Shared definitions for the fog blend unit: register indexes, fog modes,
// the 2^-x mantissa table and the control group handed to the channel blenders.
// No dependencies.
package fbu_pkg;

    // Configuration register indexes.
    localparam logic [3:0] REG_FOG_MODE     = 4'd0;
    localparam logic [3:0] REG_LINEAR_SCALE = 4'd1;
    localparam logic [3:0] REG_LINEAR_BIAS  = 4'd2;
    localparam logic [3:0] REG_EXP_DENSITY  = 4'd3;
    localparam logic [3:0] REG_EXP2_DENSITY = 4'd4;
    localparam logic [3:0] REG_FOG_RED      = 4'd5;
    localparam logic [3:0] REG_FOG_GREEN    = 4'd6;
    localparam logic [3:0] REG_FOG_BLUE     = 4'd7;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 32;

    // Fog modes.
    localparam logic [1:0] MODE_LINEAR = 2'd0;
    localparam logic [1:0] MODE_EXP    = 2'd1;
    localparam logic [1:0] MODE_EXP2   = 2'd2;
    localparam logic [1:0] MODE_NONE   = 2'd3;

    // 1.0 in the factor format, and the reset value of the linear bias.
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // Shortest exponent integer part that flushes the factor to zero.
    localparam logic [31:0] POW2_FLUSH = 32'd17;

    // Stage enables for the channel blenders.
    typedef struct packed {
        logic en_prod;
        logic en_sum;
    } chan_ctrl_t;

    // 2^(-idx/16) in Q16, for idx 0 to 16.
    function automatic logic [16:0] pow2_neg_entry(input logic [4:0] idx);
        logic [16:0] val;
        unique case (idx)
            5'd0:    val = 17'd65536;
            5'd1:    val = 17'd62757;
            5'd2:    val = 17'd60097;
            5'd3:    val = 17'd57549;
            5'd4:    val = 17'd55109;
            5'd5:    val = 17'd52773;
            5'd6:    val = 17'd50535;
            5'd7:    val = 17'd48393;
            5'd8:    val = 17'd46341;
            5'd9:    val = 17'd44376;
            5'd10:   val = 17'd42495;
            5'd11:   val = 17'd40693;
            5'd12:   val = 17'd38968;
            5'd13:   val = 17'd37316;
            5'd14:   val = 17'd35734;
            5'd15:   val = 17'd34219;
            default: val = 17'd32768;
        endcase
        return val;
    endfunction

endpackage

FILE: src/fbu_if.sv
// Handshake interfaces of the fog blend unit: pixel input, pixel output and
// the configuration write channel. Depends on fbu_pkg for the port widths.
interface fbu_pixel_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] fog_coord;
    logic        [15:0] color_red;
    logic        [15:0] color_green;
    logic        [15:0] color_blue;
    logic        [15:0] color_alpha;

    modport source (output valid, fog_coord, color_red, color_green, color_blue,
                    color_alpha, input ready);
    modport sink (input valid, fog_coord, color_red, color_green, color_blue,
                  color_alpha, output ready);
endinterface

interface fbu_pixel_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_alpha;

    modport source (output valid, out_red, out_green, out_blue, out_alpha,
                    input ready);
    modport sink (input valid, out_red, out_green, out_blue, out_alpha,
                  output ready);
endinterface

interface fbu_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [fbu_pkg::CFG_INDEX_W-1:0] index;
    logic [fbu_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: src/fbu_channel_blend.sv
// One colour channel of the fog blend: two registered products, then the
// rounded, saturated sum. Depends on fbu_pkg for the stage enable group.
module fbu_channel_blend (
    input  logic                clk,
    input  fbu_pkg::chan_ctrl_t ctrl,
    input  logic [15:0]         color,
    input  logic [15:0]         fog,
    input  logic [16:0]         factor,
    input  logic [16:0]         factor_inv,
    output logic [15:0]         result
);
    import fbu_pkg::*;

    logic [32:0] col_prod_reg;
    logic [32:0] fog_prod_reg;
    logic [15:0] result_reg;
    logic [33:0] sum;
    logic [17:0] scaled;

    always_ff @(posedge clk)
    begin
        if (ctrl.en_prod)
        begin
            col_prod_reg <= color * factor;
            fog_prod_reg <= fog * factor_inv;
        end
    end

    // Round to nearest, then saturate to the largest fraction.
    assign sum    = {1'b0, col_prod_reg} + {1'b0, fog_prod_reg} + 34'd32768;
    assign scaled = sum[33:16];

    always_ff @(posedge clk)
    begin
        if (ctrl.en_sum)
        begin
            result_reg <= (|scaled[17:16]) ? 16'hFFFF : scaled[15:0];
        end
    end

    assign result = result_reg;

endmodule

FILE: src/fog_blend_unit.sv
// Top level of the fog blend unit: configuration registers, the fog factor
// pipeline and three channel blenders. Depends on fbu_pkg, fbu_if and fbu_channel_blend.
//
// The unit takes one pixel item per clock while the output side is not stalled
// and returns one fogged pixel item for each, in order. The pipeline has
// six register stages: the coordinate times
// the selected density or scale, the linear clamp or the squaring of the
// squared exponential exponent, the 2^-x table lookup with its interpolation
// product, the factor shift, the two blend products per channel, and the
// rounded, saturated sum that forms the output register. Each stage carries
// its own valid bit and holds only while the stage after it is full and
// stalled, so bubbles close up and a stall at the output loses or repeats
// nothing. The configuration channel is always ready; registers must only
// be written while the pipeline is empty, since items read them as they
// pass. Writes to an index beyond the fog blue register are ignored. The
// alpha channel passes through untouched, and mode three forces a factor of
// one so the colour leaves unchanged.
module fog_blend_unit (
    input  logic                    clk,
    input  logic                    rst_n,
    fbu_pixel_in_if.sink            pix_in,
    fbu_pixel_out_if.source         pix_out,
    fbu_cfg_if.sink                 cfg
);
    import fbu_pkg::*;

    // Configuration registers.
    logic        [1:0]  fog_mode_reg;
    logic signed [31:0] linear_scale_reg;
    logic signed [31:0] linear_bias_reg;
    logic signed [31:0] exp_density_reg;
    logic signed [31:0] exp2_density_reg;
    logic        [15:0] fog_red_reg;
    logic        [15:0] fog_green_reg;
    logic        [15:0] fog_blue_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fog_mode_reg     <= MODE_LINEAR;
            linear_scale_reg <= '0;
            linear_bias_reg  <= 32'(ONE_Q16);
            exp_density_reg  <= '0;
            exp2_density_reg <= '0;
            fog_red_reg      <= '0;
            fog_green_reg    <= '0;
            fog_blue_reg     <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_FOG_MODE:     fog_mode_reg     <= cfg.data[1:0];
                REG_LINEAR_SCALE: linear_scale_reg <= cfg.data;
                REG_LINEAR_BIAS:  linear_bias_reg  <= cfg.data;
                REG_EXP_DENSITY:  exp_density_reg  <= cfg.data;
                REG_EXP2_DENSITY: exp2_density_reg <= cfg.data;
                REG_FOG_RED:      fog_red_reg      <= cfg.data[15:0];
                REG_FOG_GREEN:    fog_green_reg    <= cfg.data[15:0];
                REG_FOG_BLUE:     fog_blue_reg     <= cfg.data[15:0];
                default:          ;
            endcase
        end
    end

    // Stage valid bits and the backward enable chain. A stage loads when it
    // is empty or when the stage after it loads too.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic en1, en2, en3, en4, en5, en6;

    assign en6 = !v6_reg || pix_out.ready;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign pix_in.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= pix_in.valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
        end
    end

    // Stage 1: coordinate times the parameter of the selected mode, brought
    // back to Q32.16 by taking the upper bits (a floor division by 2^16).
    logic signed [31:0] s1_param;
    logic signed [63:0] s1_prod;
    logic signed [47:0] t1_reg;
    logic        [1:0]  mode1_reg;
    logic        [15:0] red1_reg, green1_reg, blue1_reg, alpha1_reg;

    always_comb
    begin
        unique case (fog_mode_reg)
            MODE_EXP:  s1_param = exp_density_reg;
            MODE_EXP2: s1_param = exp2_density_reg;
            default:   s1_param = linear_scale_reg;
        endcase
    end

    assign s1_prod = pix_in.fog_coord * s1_param;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            t1_reg     <= s1_prod[63:16];
            mode1_reg  <= fog_mode_reg;
            red1_reg   <= pix_in.color_red;
            green1_reg <= pix_in.color_green;
            blue1_reg  <= pix_in.color_blue;
            alpha1_reg <= pix_in.color_alpha;
        end
    end

    // Stage 2: linear clamp, and the square of the exponent for the squared
    // exponential mode. A magnitude of 2^24 or more already flushes to zero.
    logic [48:0] s2_lin_sum;
    logic [16:0] s2_lin_f;
    logic [47:0] s2_abs;
    logic [47:0] s2_sq;
    logic        s2_big;
    logic [48:0] s2_exp_t;

    assign s2_lin_sum = {t1_reg[47], t1_reg} + {{17{linear_bias_reg[31]}}, linear_bias_reg};

    always_comb
    begin
        priority if (s2_lin_sum[48])
            s2_lin_f = '0;
        else if (s2_lin_sum[47:0] > 48'(ONE_Q16))
            s2_lin_f = ONE_Q16;
        else
            s2_lin_f = s2_lin_sum[16:0];
    end

    assign s2_abs = t1_reg[47] ? (48'd0 - t1_reg) : t1_reg;
    assign s2_big = |s2_abs[47:24];
    assign s2_sq  = s2_abs[23:0] * s2_abs[23:0];
    assign s2_exp_t = (mode1_reg == MODE_EXP2) ? {17'd0, s2_sq[47:16]}
                                               : {t1_reg[47], t1_reg};

    logic [1:0]  mode2_reg;
    logic [16:0] lin_f2_reg;
    logic        flush2_reg;
    logic [48:0] exp_t2_reg;
    logic [15:0] red2_reg, green2_reg, blue2_reg, alpha2_reg;

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            mode2_reg  <= mode1_reg;
            lin_f2_reg <= s2_lin_f;
            flush2_reg <= (mode1_reg == MODE_EXP2) && s2_big;
            exp_t2_reg <= s2_exp_t;
            red2_reg   <= red1_reg;
            green2_reg <= green1_reg;
            blue2_reg  <= blue1_reg;
            alpha2_reg <= alpha1_reg;
        end
    end

    // Stage 3: mantissa of 2^-x from the table, interpolated on the low
    // twelve fraction bits, plus the shift that the integer part asks for.
    logic        s3_nonpos;
    logic [31:0] s3_int;
    logic [3:0]  s3_idx;
    logic [11:0] s3_w;
    logic [16:0] s3_t_lo;
    logic [16:0] s3_t_hi;
    logic [16:0] s3_diff;
    logic [23:0] s3_prod;
    logic [24:0] s3_round;
    logic [16:0] s3_mant;
    logic [16:0] s3_base;
    logic [4:0]  s3_shift;

    assign s3_nonpos = exp_t2_reg[48] || (exp_t2_reg == 49'd0);
    assign s3_int    = exp_t2_reg[47:16];
    assign s3_idx    = exp_t2_reg[15:12];
    assign s3_w      = exp_t2_reg[11:0];
    assign s3_t_lo   = pow2_neg_entry({1'b0, s3_idx});
    assign s3_t_hi   = pow2_neg_entry({1'b0, s3_idx} + 5'd1);
    assign s3_diff   = s3_t_lo - s3_t_hi;
    assign s3_prod   = s3_diff[11:0] * s3_w;
    assign s3_round  = {1'b0, s3_prod} + 25'd2048;
    assign s3_mant   = s3_t_lo - {4'd0, s3_round[24:12]};

    always_comb
    begin
        s3_shift = '0;
        unique case (mode2_reg)
            MODE_LINEAR:
                s3_base = lin_f2_reg;
            MODE_EXP, MODE_EXP2:
            begin
                priority if (flush2_reg)
                    s3_base = '0;
                else if (s3_nonpos)
                    s3_base = ONE_Q16;
                else if (s3_int >= POW2_FLUSH)
                    s3_base = '0;
                else
                begin
                    s3_base  = s3_mant;
                    s3_shift = s3_int[4:0];
                end
            end
            default:
                s3_base = ONE_Q16;
        endcase
    end

    logic [16:0] base3_reg;
    logic [4:0]  shift3_reg;
    logic [15:0] red3_reg, green3_reg, blue3_reg, alpha3_reg;

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            base3_reg  <= s3_base;
            shift3_reg <= s3_shift;
            red3_reg   <= red2_reg;
            green3_reg <= green2_reg;
            blue3_reg  <= blue2_reg;
            alpha3_reg <= alpha2_reg;
        end
    end

    // Stage 4: final factor and its complement.
    logic [16:0] s4_f;
    logic [16:0] f4_reg;
    logic [16:0] inv4_reg;
    logic [15:0] red4_reg, green4_reg, blue4_reg, alpha4_reg;

    assign s4_f = base3_reg >> shift3_reg;

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            f4_reg     <= s4_f;
            inv4_reg   <= ONE_Q16 - s4_f;
            red4_reg   <= red3_reg;
            green4_reg <= green3_reg;
            blue4_reg  <= blue3_reg;
            alpha4_reg <= alpha3_reg;
        end
    end

    // Stages 5 and 6: per-channel blend; alpha travels alongside.
    chan_ctrl_t  chan_ctrl;
    logic [15:0] alpha5_reg;
    logic [15:0] alpha6_reg;

    assign chan_ctrl.en_prod = en5;
    assign chan_ctrl.en_sum  = en6;

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            alpha5_reg <= alpha4_reg;
        end
        if (en6)
        begin
            alpha6_reg <= alpha5_reg;
        end
    end

    fbu_channel_blend u_red (
        .clk        (clk),
        .ctrl       (chan_ctrl),
        .color      (red4_reg),
        .fog        (fog_red_reg),
        .factor     (f4_reg),
        .factor_inv (inv4_reg),
        .result     (pix_out.out_red)
    );

    fbu_channel_blend u_green (
        .clk        (clk),
        .ctrl       (chan_ctrl),
        .color      (green4_reg),
        .fog        (fog_green_reg),
        .factor     (f4_reg),
        .factor_inv (inv4_reg),
        .result     (pix_out.out_green)
    );

    fbu_channel_blend u_blue (
        .clk        (clk),
        .ctrl       (chan_ctrl),
        .color      (blue4_reg),
        .fog        (fog_blue_reg),
        .factor     (f4_reg),
        .factor_inv (inv4_reg),
        .result     (pix_out.out_blue)
    );

    assign pix_out.valid     = v6_reg;
    assign pix_out.out_alpha = alpha6_reg;

endmodule
